/* sv/mkd_pkg.sv */
`timescale 1ns / 1ps
package mkd_pkg;

  // buffer capacities of the text path (only the counts are kept here)
  localparam int WORD_CAPACITY     = 32;
  localparam int SENTENCE_CAPACITY = 32;

  localparam int LIW_W = $clog2(WORD_CAPACITY);
  localparam int WIS_W = $clog2(SENTENCE_CAPACITY);

  localparam int TICK_W  = 8;
  localparam int BITS_W  = 8;
  localparam int LEN_W   = 4;
  localparam int CODE_W  = 7;
  localparam int TOTAL_W = 5;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DASH_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENTENCE_GAP = 3'd4;

  localparam logic [TICK_W-1:0] DASH_MIN_RST     = 8'd5;
  localparam logic [TICK_W-1:0] DELETE_MIN_RST   = 8'd20;
  localparam logic [TICK_W-1:0] LETTER_GAP_RST   = 8'd8;
  localparam logic [TICK_W-1:0] WORD_GAP_RST     = 8'd20;
  localparam logic [TICK_W-1:0] SENTENCE_GAP_RST = 8'd32;

  // result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MAX_RES = 3;
  localparam int NRES_W  = 2;

  typedef enum logic [2:0] {
    KIND_DOT      = 3'd0,
    KIND_DASH     = 3'd1,
    KIND_DELETE   = 3'd2,
    KIND_LETTER   = 3'd3,
    KIND_WORD     = 3'd4,
    KIND_SENTENCE = 3'd5
  } mkd_kind_e;

  typedef struct packed {
    mkd_kind_e            kind;
    logic [CODE_W-1:0]    code;
    logic                 stored;
    logic [TOTAL_W-1:0]   total;
  } mkd_res_t;

  // all results of one tick, slot 0 delivered first
  typedef struct packed {
    logic [NRES_W-1:0]         cnt;
    mkd_res_t [MAX_RES-1:0]    res;
  } mkd_entry_t;

  typedef struct packed {
    logic       valid;
    mkd_entry_t entry;
  } mkd_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mkd_qstat_t;

  localparam logic [CODE_W-1:0] UNKNOWN_CHAR = 7'd63;
  localparam int                LETTER_A     = 97;
  localparam int                NUM_LETTERS  = 26;

  // per letter a..z: element count and pattern, dash = 1, first element in msb
  localparam logic [LEN_W-1:0] SYM_LEN [NUM_LETTERS] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2,
    4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
  };
  localparam logic [3:0] SYM_CODE [NUM_LETTERS] = '{
    4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
    4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
  };

  function automatic logic [CODE_W-1:0] lookup_letter(logic [BITS_W-1:0] bits,
                                                      logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] ch;
    ch = UNKNOWN_CHAR;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (SYM_LEN[i] == len && {4'b0, SYM_CODE[i]} == bits) begin
        ch = CODE_W'(LETTER_A + i);
      end
    end
    return ch;
  endfunction

endpackage

/* sv/mkd_key_if.sv */
`timescale 1ns / 1ps
interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source (output valid, output key_down, input ready);
  modport sink (input valid, input key_down, output ready);
endinterface

/* sv/mkd_evt_if.sv */
`timescale 1ns / 1ps
interface mkd_evt_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   event_kind;
  logic [mkd_pkg::CODE_W-1:0]   letter_code;
  logic                         was_stored;
  logic [mkd_pkg::TOTAL_W-1:0]  word_total;
  logic                         last_of_tick;

  modport source (output valid, output event_kind, output letter_code, output was_stored,
                  output word_total, output last_of_tick, input ready);
  modport sink (input valid, input event_kind, input letter_code, input was_stored,
                input word_total, input last_of_tick, output ready);
endinterface

/* sv/mkd_front.sv */
`timescale 1ns / 1ps
module mkd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  mkd_key_if.sink                          key,
  input  mkd_pkg::mkd_qstat_t              qstat_i,
  output mkd_pkg::mkd_push_t               push_o
);

  logic [mkd_pkg::TICK_W-1:0] dash_min_q, delete_min_q, letter_gap_q, word_gap_q;
  logic [mkd_pkg::TICK_W-1:0] sentence_gap_q;

  logic [mkd_pkg::TICK_W-1:0] press_q, press_d, gap_q, gap_d, gap_n;
  logic [mkd_pkg::BITS_W-1:0] bits_q, bits_d;
  logic [mkd_pkg::LEN_W-1:0]  len_q, len_d;
  logic [mkd_pkg::LIW_W-1:0]  letters_q, letters_d;
  logic [mkd_pkg::WIS_W-1:0]  words_q, words_d;

  mkd_pkg::mkd_entry_t        entry;
  logic [mkd_pkg::NRES_W-1:0] nres;
  logic                       dash;
  logic                       fit;
  logic [31:0]                wtot;
  logic                       accept;

  assign key.ready = !qstat_i.full;
  assign accept    = key.valid && key.ready;

  always_comb begin
    press_d   = press_q;
    gap_d     = gap_q;
    bits_d    = bits_q;
    len_d     = len_q;
    letters_d = letters_q;
    words_d   = words_q;
    entry     = '0;
    nres      = '0;
    dash      = 1'b0;
    fit       = 1'b0;
    gap_n     = gap_q;
    wtot      = '0;
    if (key.key_down) begin
      if (press_q != mkd_pkg::TICK_MAX) begin
        press_d = press_q + 1'b1;
      end
      gap_d = '0;
    end else if (press_q != '0) begin
      // release tick: sort the press
      if (press_q >= delete_min_q && letters_q != '0) begin
        letters_d = letters_q - 1'b1;
        entry.res[0].kind = mkd_pkg::KIND_DELETE;
      end else begin
        dash   = press_q >= dash_min_q;
        bits_d = {bits_q[mkd_pkg::BITS_W-2:0], dash};
        if (len_q != mkd_pkg::LEN_MAX) begin
          len_d = len_q + 1'b1;
        end
        entry.res[0].kind = dash ? mkd_pkg::KIND_DASH : mkd_pkg::KIND_DOT;
      end
      nres    = 2'd1;
      press_d = '0;
      gap_d   = '0;
    end else begin
      if (gap_q != mkd_pkg::TICK_MAX) begin
        gap_n = gap_q + 1'b1;
      end
      gap_d = gap_n;
      if (gap_n >= letter_gap_q && len_q != '0) begin
        fit = letters_d < mkd_pkg::LIW_W'(mkd_pkg::WORD_CAPACITY - 1);
        if (fit) begin
          letters_d = letters_d + 1'b1;
        end
        entry.res[nres].kind   = mkd_pkg::KIND_LETTER;
        entry.res[nres].code   = mkd_pkg::lookup_letter(bits_q, len_q);
        entry.res[nres].stored = fit;
        nres   = nres + 1'b1;
        bits_d = '0;
        len_d  = '0;
      end
      if (gap_n >= word_gap_q && letters_d != '0) begin
        fit = words_d < mkd_pkg::WIS_W'(mkd_pkg::SENTENCE_CAPACITY - 1);
        if (fit) begin
          words_d = words_d + 1'b1;
        end
        entry.res[nres].kind   = mkd_pkg::KIND_WORD;
        entry.res[nres].stored = fit;
        nres      = nres + 1'b1;
        letters_d = '0;
      end
      if (gap_n >= sentence_gap_q && words_d != '0) begin
        wtot = 32'(words_d);
        entry.res[nres].kind  = mkd_pkg::KIND_SENTENCE;
        entry.res[nres].total = wtot[mkd_pkg::TOTAL_W-1:0];
        nres    = nres + 1'b1;
        words_d = '0;
        gap_d   = '0;
      end
    end
    entry.cnt = nres;
  end

  assign push_o.valid = accept && (nres != '0);
  assign push_o.entry = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= '0;
      gap_q     <= '0;
      bits_q    <= '0;
      len_q     <= '0;
      letters_q <= '0;
      words_q   <= '0;
    end else if (accept) begin
      press_q   <= press_d;
      gap_q     <= gap_d;
      bits_q    <= bits_d;
      len_q     <= len_d;
      letters_q <= letters_d;
      words_q   <= words_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dash_min_q     <= mkd_pkg::DASH_MIN_RST;
      delete_min_q   <= mkd_pkg::DELETE_MIN_RST;
      letter_gap_q   <= mkd_pkg::LETTER_GAP_RST;
      word_gap_q     <= mkd_pkg::WORD_GAP_RST;
      sentence_gap_q <= mkd_pkg::SENTENCE_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mkd_pkg::CFG_DASH_MIN:     dash_min_q     <= cfg_wdata_i;
        mkd_pkg::CFG_DELETE_MIN:   delete_min_q   <= cfg_wdata_i;
        mkd_pkg::CFG_LETTER_GAP:   letter_gap_q   <= cfg_wdata_i;
        mkd_pkg::CFG_WORD_GAP:     word_gap_q     <= cfg_wdata_i;
        mkd_pkg::CFG_SENTENCE_GAP: sentence_gap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  // a release tick always yields exactly one result
  a_release_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !key.key_down && press_q != '0) |-> (push_o.valid && push_o.entry.cnt == 2'd1))
    else $error("release tick did not queue exactly one result");
`endif

endmodule

/* sv/mkd_queue.sv */
`timescale 1ns / 1ps
module mkd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mkd_pkg::mkd_push_t      push_i,
  input  logic                    pop_i,
  output mkd_pkg::mkd_qstat_t     qstat_o,
  output mkd_pkg::mkd_entry_t     head_o
);

  mkd_pkg::mkd_entry_t         mem_q [mkd_pkg::QUEUE_DEPTH];
  logic [mkd_pkg::QPTR_W-1:0]  wr_q, rd_q;
  logic [mkd_pkg::QCNT_W-1:0]  cnt_q;

  assign qstat_o.full  = cnt_q == mkd_pkg::QCNT_W'(mkd_pkg::QUEUE_DEPTH);
  assign qstat_o.empty = cnt_q == '0;
  assign head_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i.valid && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && qstat_o.full))
    else $error("push into full result queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && qstat_o.empty))
    else $error("pop from empty result queue");
`endif

endmodule

/* sv/mkd_back.sv */
`timescale 1ns / 1ps
module mkd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mkd_pkg::mkd_qstat_t     qstat_i,
  input  mkd_pkg::mkd_entry_t     head_i,
  output logic                    pop_o,
  mkd_evt_if.source               evt
);

  logic [mkd_pkg::NRES_W-1:0] idx_q;
  logic                       last;
  logic                       beat;
  mkd_pkg::mkd_res_t          cur;

  assign cur  = head_i.res[idx_q];
  assign last = idx_q == head_i.cnt - 1'b1;
  assign beat = evt.valid && evt.ready;

  assign evt.valid        = !qstat_i.empty;
  assign evt.event_kind   = cur.kind;
  assign evt.letter_code  = cur.code;
  assign evt.was_stored   = cur.stored;
  assign evt.word_total   = cur.total;
  assign evt.last_of_tick = last;

  assign pop_o = beat && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (beat) begin
      idx_q <= last ? '0 : idx_q + 1'b1;
    end
  end

`ifndef SYNTH
  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt.valid |-> (idx_q < head_i.cnt))
    else $error("slot index beyond results of head tick");
  a_idx_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !last) |=> (idx_q == $past(idx_q) + 1'b1))
    else $error("slot index did not advance within a tick");
`endif

endmodule

/* sv/morse_key_decoder.sv */
`timescale 1ns / 1ps
// morse key decoder
// key_i carries one beat per timebase tick with the sampled key level; evt_o
// carries the decoded events (dot, dash, delete, letter, word end, sentence end),
// last_of_tick marking the final event caused by a tick. cfg_we_i/cfg_idx_i/
// cfg_wdata_i write the five timing thresholds; write them only while idle.
// the front takes one tick per cycle while the queue is not full, updates
// press/gap counters and the symbol, and queues all events of that tick as one
// entry in a four-entry queue. the back hands the events out one beat per cycle
// while the receiver is ready. the first event of a tick is offered once its
// entry is registered in the queue and has reached its head. a tick with several
// events holds the queue head until all of them have gone out on the single
// output port. ticks with no event never occupy the queue.
// when the receiver stalls, the queue fills and key_i.ready drops once four
// ticks with results are waiting; no event is lost or repeated.
// reset clears all counters, the symbol and the queue, and loads the threshold
// defaults (dash 5, delete 20, letter gap 8, word gap 20, sentence gap 32).
module morse_key_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  mkd_key_if.sink                          key_i,
  mkd_evt_if.source                        evt_o
);

  // front to queue
  mkd_pkg::mkd_push_t   push;
  // queue status seen by both sides
  mkd_pkg::mkd_qstat_t  qstat;
  mkd_pkg::mkd_entry_t  head;
  logic                 pop;

  // counters, thresholds and event classification
  mkd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key         (key_i),
    .qstat_i     (qstat),
    .push_o      (push)
  );

  // per-tick event bundles, decouples key side from event side
  mkd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .qstat_o (qstat),
    .head_o  (head)
  );

  // serializes a bundle into event beats
  mkd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .head_i  (head),
    .pop_o   (pop),
    .evt     (evt_o)
  );

endmodule

/* verif/mkd_checker.sv */
`timescale 1ns / 1ps
// watches both channels and the register port, predicts events per key tick
module mkd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mkd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mkd_key_if                             key_i,
  mkd_evt_if                             evt_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             ticks_o,
  output int                             events_o,
  output logic [5:0]                     kinds_o,
  output int                             full_o,
  output int                             unknown_o
);

  localparam logic [mkd_pkg::CODE_W-1:0] QMARK = 7'h3f;

  typedef struct packed {
    mkd_pkg::mkd_kind_e          kind;
    logic [mkd_pkg::CODE_W-1:0]  code;
    logic                        stored;
    logic [mkd_pkg::TOTAL_W-1:0] total;
    logic                        last;
  } key_evt_t;

  key_evt_t evt_expq[$];

  // thresholds as last written
  logic [mkd_pkg::TICK_W-1:0] thr_dash, thr_delete, thr_letter, thr_word, thr_sentence;

  // decoder state
  logic [mkd_pkg::TICK_W-1:0] press_cnt, gap_cnt;
  logic [mkd_pkg::BITS_W-1:0] sym_bits;
  logic [mkd_pkg::LEN_W-1:0]  sym_len;
  logic [mkd_pkg::LIW_W-1:0]  word_letters;
  logic [mkd_pkg::WIS_W-1:0]  sentence_words;

  int n_err, n_ticks, n_events, n_full, n_unknown;
  logic [5:0] seen;

  // elements first to last, dash = 1
  function automatic logic [mkd_pkg::CODE_W-1:0] morse_char(
      logic [mkd_pkg::BITS_W-1:0] bits, logic [mkd_pkg::LEN_W-1:0] len);
    logic [7:0] ch;
    case ({len, bits})
      {4'd2, 8'b01}:   ch = "a";
      {4'd4, 8'b1000}: ch = "b";
      {4'd4, 8'b1010}: ch = "c";
      {4'd3, 8'b100}:  ch = "d";
      {4'd1, 8'b0}:    ch = "e";
      {4'd4, 8'b0010}: ch = "f";
      {4'd3, 8'b110}:  ch = "g";
      {4'd4, 8'b0000}: ch = "h";
      {4'd2, 8'b00}:   ch = "i";
      {4'd4, 8'b0111}: ch = "j";
      {4'd3, 8'b101}:  ch = "k";
      {4'd4, 8'b0100}: ch = "l";
      {4'd2, 8'b11}:   ch = "m";
      {4'd2, 8'b10}:   ch = "n";
      {4'd3, 8'b111}:  ch = "o";
      {4'd4, 8'b0110}: ch = "p";
      {4'd4, 8'b1101}: ch = "q";
      {4'd3, 8'b010}:  ch = "r";
      {4'd3, 8'b000}:  ch = "s";
      {4'd1, 8'b1}:    ch = "t";
      {4'd3, 8'b001}:  ch = "u";
      {4'd4, 8'b0001}: ch = "v";
      {4'd3, 8'b011}:  ch = "w";
      {4'd4, 8'b1001}: ch = "x";
      {4'd4, 8'b1011}: ch = "y";
      {4'd4, 8'b1100}: ch = "z";
      default:         ch = {1'b0, QMARK};
    endcase
    return ch[mkd_pkg::CODE_W-1:0];
  endfunction

  function automatic key_evt_t mk_evt(mkd_pkg::mkd_kind_e kind,
                                      logic [mkd_pkg::CODE_W-1:0] code,
                                      logic stored, logic [mkd_pkg::TOTAL_W-1:0] total);
    key_evt_t e;
    e.kind   = kind;
    e.code   = code;
    e.stored = stored;
    e.total  = total;
    e.last   = 1'b0;
    return e;
  endfunction

  task automatic predict_tick(input logic down);
    key_evt_t tick_evts[$];
    logic     fits;
    logic     is_dash;
    if (down) begin
      if (press_cnt != '1) press_cnt++;
      gap_cnt = '0;
    end else if (press_cnt != '0) begin
      if (press_cnt >= thr_delete && word_letters != '0) begin
        word_letters--;
        tick_evts.push_back(mk_evt(mkd_pkg::KIND_DELETE, '0, 1'b0, '0));
      end else begin
        is_dash  = (press_cnt >= thr_dash);
        sym_bits = {sym_bits[mkd_pkg::BITS_W-2:0], is_dash};
        if (sym_len != '1) sym_len++;
        tick_evts.push_back(mk_evt(is_dash ? mkd_pkg::KIND_DASH : mkd_pkg::KIND_DOT,
                                   '0, 1'b0, '0));
      end
      press_cnt = '0;
      gap_cnt   = '0;
    end else begin
      if (gap_cnt != '1) gap_cnt++;
      if (gap_cnt >= thr_letter && sym_len != '0) begin
        fits = (word_letters < mkd_pkg::LIW_W'(mkd_pkg::WORD_CAPACITY - 1));
        if (fits) word_letters++;
        tick_evts.push_back(mk_evt(mkd_pkg::KIND_LETTER, morse_char(sym_bits, sym_len),
                                   fits, '0));
        sym_bits = '0;
        sym_len  = '0;
      end
      if (gap_cnt >= thr_word && word_letters != '0) begin
        fits = (sentence_words < mkd_pkg::WIS_W'(mkd_pkg::SENTENCE_CAPACITY - 1));
        if (fits) sentence_words++;
        tick_evts.push_back(mk_evt(mkd_pkg::KIND_WORD, '0, fits, '0));
        word_letters = '0;
      end
      if (gap_cnt >= thr_sentence && sentence_words != '0) begin
        tick_evts.push_back(mk_evt(mkd_pkg::KIND_SENTENCE, '0, 1'b0,
                                   mkd_pkg::TOTAL_W'(sentence_words)));
        sentence_words = '0;
        gap_cnt        = '0;
      end
    end
    if (tick_evts.size() > 0) tick_evts[tick_evts.size()-1].last = 1'b1;
    foreach (tick_evts[i]) evt_expq.push_back(tick_evts[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : mon
    key_evt_t got;
    key_evt_t want;
    if (!rst_ni) begin
      thr_dash       = mkd_pkg::DASH_MIN_RST;
      thr_delete     = mkd_pkg::DELETE_MIN_RST;
      thr_letter     = mkd_pkg::LETTER_GAP_RST;
      thr_word       = mkd_pkg::WORD_GAP_RST;
      thr_sentence   = mkd_pkg::SENTENCE_GAP_RST;
      press_cnt      = '0;
      gap_cnt        = '0;
      sym_bits       = '0;
      sym_len        = '0;
      word_letters   = '0;
      sentence_words = '0;
      evt_expq.delete();
      n_err     = 0;
      n_ticks   = 0;
      n_events  = 0;
      n_full    = 0;
      n_unknown = 0;
      seen      = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mkd_pkg::CFG_DASH_MIN:     thr_dash     = cfg_wdata_i;
          mkd_pkg::CFG_DELETE_MIN:   thr_delete   = cfg_wdata_i;
          mkd_pkg::CFG_LETTER_GAP:   thr_letter   = cfg_wdata_i;
          mkd_pkg::CFG_WORD_GAP:     thr_word     = cfg_wdata_i;
          mkd_pkg::CFG_SENTENCE_GAP: thr_sentence = cfg_wdata_i;
          default: ;
        endcase
      end
      if (key_i.valid && key_i.ready) begin
        predict_tick(key_i.key_down);
        n_ticks++;
      end
      if (evt_i.valid && evt_i.ready) begin
        got.kind   = mkd_pkg::mkd_kind_e'(evt_i.event_kind);
        got.code   = evt_i.letter_code;
        got.stored = evt_i.was_stored;
        got.total  = evt_i.word_total;
        got.last   = evt_i.last_of_tick;
        n_events++;
        if (evt_expq.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%t unexpected event: kind %0d code %0d stored %b total %0d last %b",
                     $realtime, got.kind, got.code, got.stored, got.total, got.last);
        end else begin
          want = evt_expq.pop_front();
          seen[want.kind] = 1'b1;
          if ((want.kind == mkd_pkg::KIND_LETTER || want.kind == mkd_pkg::KIND_WORD) &&
              !want.stored) n_full++;
          if (want.kind == mkd_pkg::KIND_LETTER && want.code == QMARK) n_unknown++;
          if (got !== want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("%t event %0d mismatch", $realtime, n_events);
              $display("  expected kind %0d code %0d stored %b total %0d last %b",
                       want.kind, want.code, want.stored, want.total, want.last);
              $display("  actual   kind %0d code %0d stored %b total %0d last %b",
                       got.kind, got.code, got.stored, got.total, got.last);
            end
          end
        end
      end
    end
    errors_o  <= n_err;
    pending_o <= evt_expq.size();
    ticks_o   <= n_ticks;
    events_o  <= n_events;
    kinds_o   <= seen;
    full_o    <= n_full;
    unknown_o <= n_unknown;
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// top of the morse key decoder bench: clock, reset, key ticks, receiver ready,
// register writes and the verdict; checking lives in mkd_checker
module tb;

  // register indexes in the order the timing task takes its values
  localparam logic [mkd_pkg::CFG_IDX_W-1:0] REG_ORDER [5] = '{
    mkd_pkg::CFG_DASH_MIN, mkd_pkg::CFG_DELETE_MIN, mkd_pkg::CFG_LETTER_GAP,
    mkd_pkg::CFG_WORD_GAP, mkd_pkg::CFG_SENTENCE_GAP
  };
  // first index past the real registers, writes there must change nothing
  localparam int CFG_FIRST_UNUSED = int'(mkd_pkg::CFG_SENTENCE_GAP) + 1;
  localparam int RX_LONG_STALL    = 200;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [mkd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mkd_key_if key_ch ();
  mkd_evt_if evt_ch ();

  int         n_errors, n_pending, n_ticks, n_events, n_full, n_unknown;
  logic [5:0] kinds_seen;

  // sender and receiver idle chances in percent
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic stall_arm;

  // thresholds as currently programmed, used to shape the key timing
  int dash_t, delete_t, letter_t, word_t, sentence_t;
  int n_sent;

  morse_key_decoder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .key_i       (key_ch),
    .evt_o       (evt_ch)
  );

  mkd_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .key_i       (key_ch),
    .evt_i       (evt_ch),
    .errors_o    (n_errors),
    .pending_o   (n_pending),
    .ticks_o     (n_ticks),
    .events_o    (n_events),
    .kinds_o     (kinds_seen),
    .full_o      (n_full),
    .unknown_o   (n_unknown)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs or loses an event
  initial begin
    #400_000;
    $display("timeout: run did not complete, %0d events still owed", n_pending);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver side: random ready, plus one long hold-off once armed so the
  // event queue fills and the block has to push back on key ticks
  initial begin : rx_side
    int stall_left;
    bit stalled_once;
    stall_left   = 0;
    stalled_once = 1'b0;
    evt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_arm && !stalled_once) begin
        stalled_once = 1'b1;
        stall_left   = RX_LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // random value in [lo, hi], kept within a few ticks of lo so gaps stay short;
  // an empty range collapses to lo
  function automatic int pick(int lo, int hi);
    int top_v;
    top_v = (hi < lo) ? lo : ((hi > lo + 3) ? lo + 3 : hi);
    return int'($urandom_range(top_v, lo));
  endfunction

  // one key beat; valid stays up into the next call, which always assigns it
  // again in the same step, so no beat is ever offered twice
  task automatic send_tick(input logic down);
    while ($urandom_range(99) < tx_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_down <= down;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // hold the key for n ticks, then the release tick
  task automatic press(input int n);
    for (int i = 0; i < n; i++) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic pause(input int n);
    for (int i = 0; i < n; i++) send_tick(1'b0);
  endtask

  // stop offering beats until every predicted event has come out
  task automatic drain();
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // program all five thresholds while idle; optionally poke the unused indexes
  task automatic set_timing(input int d, input int del, input int lg, input int wg,
                            input int sg, input bit junk);
    int vals [5];
    vals = '{d, del, lg, wg, sg};
    drain();
    // events of the last tick may still be on their way out of the queue
    repeat (4) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_ORDER[i];
      cfg_wdata <= mkd_pkg::CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    if (junk) begin
      for (int j = CFG_FIRST_UNUSED; j < 2**mkd_pkg::CFG_IDX_W; j++) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= mkd_pkg::CFG_IDX_W'(j);
        cfg_wdata <= mkd_pkg::CFG_DATA_W'($urandom);
        @(posedge clk);
      end
    end
    cfg_we     <= 1'b0;
    dash_t     = d;
    delete_t   = del;
    letter_t   = lg;
    word_t     = wg;
    sentence_t = sg;
  endtask

  // one letter of random dots and dashes
  task automatic key_letter(input int elems);
    for (int i = 0; i < elems; i++) begin
      if ($urandom_range(1) == 0) press((dash_t > 1) ? pick(1, dash_t - 1) : 1);
      else press(pick((dash_t < 1) ? 1 : dash_t, delete_t - 1));
    end
  endtask

  // a well-formed word: letters split by letter gaps, a delete now and then,
  // closed by a word gap or a gap long enough to end the sentence too
  task automatic send_word(input int n_letters);
    for (int i = 0; i < n_letters; i++) begin
      // mostly real lengths, sometimes too long to be a letter
      key_letter(($urandom_range(9) == 0) ? int'($urandom_range(6, 5))
                                          : int'($urandom_range(4, 1)));
      if ($urandom_range(7) == 0) begin
        pause(pick(letter_t, word_t - 1));
        press(pick((delete_t < 1) ? 1 : delete_t, delete_t + 2));
      end
      if (i < n_letters - 1) pause(pick(letter_t, word_t - 1));
    end
    if ($urandom_range(2) == 0) pause(pick(sentence_t, sentence_t + 3));
    else pause(pick(word_t, sentence_t - 1));
  endtask

  // random words with some raw key noise, draining every dozen rounds
  task automatic random_run(input int n);
    int stop_at;
    int rounds;
    stop_at = n_sent + n;
    rounds  = 0;
    while (n_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(15, 5)) send_tick(1'($urandom_range(1)));
      end else begin
        send_word($urandom_range(4, 1));
      end
      rounds++;
      if (rounds % 12 == 0) drain();
    end
  endtask

  initial begin : stim
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    key_ch.valid    <= 1'b0;
    key_ch.key_down <= 1'b0;
    stall_arm       <= 1'b0;
    rx_idle_pct     <= 76;
    tx_idle_pct     = 23;
    n_sent          = 0;
    dash_t          = 5;
    delete_t        = 20;
    letter_t        = 8;
    word_t          = 20;
    sentence_t      = 32;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: tight thresholds so every event kind shows up in a few ticks
    set_timing(2, 4, 1, 2, 3, 1'b0);
    press(1);     // dot
    pause(1);     // closes the letter e
    press(4);     // long press with a letter in the word: delete
    press(2);     // dash
    press(2);     // dash
    pause(1);     // letter m
    pause(1);     // word end
    pause(1);     // sentence end with one word

    // all thresholds at zero: every press a dash, letter, word and sentence in
    // one tick; the unused indexes get written too
    set_timing(0, 0, 0, 0, 0, 1'b1);
    random_run(30);

    // back to the reset timing
    set_timing(5, 20, 8, 20, 32, 1'b0);
    random_run(80);

    // swap the idle pattern, then hold the receiver off for a long stretch
    tx_idle_pct = 76;
    rx_idle_pct <= 23;
    set_timing(2, 6, 2, 4, 7, 1'b0);
    stall_arm <= 1'b1;
    random_run(100);

    // fill the sentence past its capacity with one-letter words, each closed
    // on its first gap tick, then end the sentence
    set_timing(2, 3, 1, 1, 2, 1'b0);
    repeat (32) begin
      press(1);
      pause(1);
    end
    pause(2);

    // no idling from here on
    tx_idle_pct = 0;
    rx_idle_pct <= 0;

    // fill the word past its capacity, delete one letter, then overflow the
    // symbol length and close letter, word and sentence
    set_timing(255, 4, 1, 2, 3, 1'b0);
    repeat (32) begin
      press(1);
      pause(1);
    end
    press(4);
    repeat (17) press(1);
    pause(1);
    pause(2);

    set_timing(3, 8, 3, 6, 10, 1'b1);
    random_run(40);

    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d key ticks, %0d events checked, event kinds seen %b",
             n_ticks, n_events, kinds_seen);
    $display("%0d letters or words found their buffer full, %0d unknown letters",
             n_full, n_unknown);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d event errors", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/mkd_pkg.sv
sv/mkd_key_if.sv
sv/mkd_evt_if.sv
sv/mkd_front.sv
sv/mkd_queue.sv
sv/mkd_back.sv
sv/morse_key_decoder.sv
verif/mkd_checker.sv
verif/tb.sv
